FILE: sv/mrf_pkg.sv
// package: types, codes and constants of the matrix rolling fingerprint unit
`default_nettype none
package mrf_pkg;

  localparam int unsigned ENTRY_W   = 31;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STEP_W    = $clog2(BYTE_W);
  localparam int unsigned BIT_IDX_W = $clog2(ENTRY_W);

  localparam logic [ENTRY_W-1:0] PRIME_RESET = {ENTRY_W{1'b1}};
  localparam logic [ENTRY_W-1:0] PRIME_MIN   = ENTRY_W'(3);

  // operation codes
  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_ROLL   = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [BYTE_W-1:0] new_byte;
    logic [BYTE_W-1:0] old_byte;
  } in_item_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_row0_col0;
    logic [ENTRY_W-1:0] entry_row0_col1;
    logic [ENTRY_W-1:0] entry_row1_col0;
    logic [ENTRY_W-1:0] entry_row1_col1;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ROW,
    ST_COL,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: sv/matrix_rolling_fingerprint_unit.sv
// top level: 2x2 matrix rolling fingerprint mod p on a shared two-lane modular add/sub unit
// start and append run the column steps over the new byte, roll runs the row steps over the old
// byte and then the column steps; unused code 3 passes the matrix on unchanged. an append or roll
// after a modulus write first reduces the stored matrix bit-serially. the add/sub unit steps once
// per byte bit; one item at a time, ready again once the result sits in the output register.
// reset (synchronous, rst high) loads the identity matrix and modulus 2^31-1
`default_nettype none
module matrix_rolling_fingerprint_unit
  import mrf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [ENTRY_W-1:0] cfg_wr_data
);

  // registers
  state_t                 state, state_next;
  logic [ENTRY_W-1:0]     prime;
  logic                   dirty, dirty_next;      // stored matrix may exceed the modulus
  logic [ENTRY_W-1:0]     m [4];                  // row-major fingerprint
  logic [ENTRY_W-1:0]     m_next [4];
  in_item_t               item, item_next;
  logic [STEP_W-1:0]      cnt, cnt_next;
  logic [BIT_IDX_W-1:0]   bi, bi_next;
  logic                   sel, sel_next;          // entry pair under reduction
  logic [ENTRY_W-1:0]     rem [2];
  logic [ENTRY_W-1:0]     rem_next [2];
  logic                   out_valid_next;
  out_item_t              out_data_next;

  // shared lane unit operands
  logic [ENTRY_W-1:0] lane_a [2];
  logic [ENTRY_W-1:0] lane_b [2];
  logic               lane_cin [2];
  logic               lane_sub;
  logic [ENTRY_W-1:0] lane_res [2];

  logic               in_xfer;
  logic               out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // two modular add/sub lanes; operands are reduced so one correction suffices
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [ENTRY_W:0] s;
      logic [ENTRY_W:0] t;
      s = '0;
      t = '0;
      if (lane_sub) begin
        s = {1'b0, lane_a[l]} - {1'b0, lane_b[l]};
        t = s + {1'b0, prime};
        lane_res[l] = s[ENTRY_W] ? t[ENTRY_W-1:0] : s[ENTRY_W-1:0];
      end else begin
        s = {1'b0, lane_a[l]} + {1'b0, lane_b[l]} + {{ENTRY_W{1'b0}}, lane_cin[l]};
        t = s - {1'b0, prime};
        lane_res[l] = (s >= {1'b0, prime}) ? t[ENTRY_W-1:0] : s[ENTRY_W-1:0];
      end
    end
  end

  // lane operand selection
  always_comb begin
    lane_sub = 1'b0;
    for (int l = 0; l < 2; l++) begin
      lane_a[l]   = rem[l];
      lane_b[l]   = rem[l];
      lane_cin[l] = m[{sel, 1'(l)}][bi];
    end
    unique case (state)
      ST_ROW: begin
        lane_sub = 1'b1;
        if (item.old_byte[cnt]) begin
          // row0 -= row1
          lane_a[0] = m[0]; lane_b[0] = m[2];
          lane_a[1] = m[1]; lane_b[1] = m[3];
        end else begin
          // row1 -= row0
          lane_a[0] = m[2]; lane_b[0] = m[0];
          lane_a[1] = m[3]; lane_b[1] = m[1];
        end
      end
      ST_COL: begin
        // both column ops sum the row's two entries
        lane_a[0] = m[0]; lane_b[0] = m[1]; lane_cin[0] = 1'b0;
        lane_a[1] = m[2]; lane_b[1] = m[3]; lane_cin[1] = 1'b0;
      end
      ST_IDLE, ST_REDUCE, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next     = state;
    dirty_next     = dirty;
    item_next      = item;
    cnt_next       = cnt;
    bi_next        = bi;
    sel_next       = sel;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    for (int i = 0; i < 4; i++) m_next[i] = m[i];
    for (int l = 0; l < 2; l++) rem_next[l] = rem[l];

    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          item_next = in_data;
          cnt_next  = '0;
          bi_next   = BIT_IDX_W'(ENTRY_W - 1);
          sel_next  = 1'b0;
          for (int l = 0; l < 2; l++) rem_next[l] = '0;
          priority if (in_data.func == FUNC_START) begin
            m_next[0] = ENTRY_W'(1);
            m_next[1] = '0;
            m_next[2] = '0;
            m_next[3] = ENTRY_W'(1);
            dirty_next = 1'b0;
            state_next = ST_COL;
          end else if (in_data.func == FUNC_APPEND) begin
            state_next = dirty ? ST_REDUCE : ST_COL;
          end else if (in_data.func == FUNC_ROLL) begin
            state_next = dirty ? ST_REDUCE : ST_ROW;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_REDUCE: begin
        // shift-subtract remainder, one bit of each entry in the pair per cycle
        for (int l = 0; l < 2; l++) rem_next[l] = lane_res[l];
        bi_next = bi - 1'b1;
        if (bi == '0) begin
          m_next[{sel, 1'b0}] = lane_res[0];
          m_next[{sel, 1'b1}] = lane_res[1];
          for (int l = 0; l < 2; l++) rem_next[l] = '0;
          bi_next  = BIT_IDX_W'(ENTRY_W - 1);
          sel_next = 1'b1;
          if (sel) begin
            dirty_next = 1'b0;
            state_next = (item.func == FUNC_ROLL) ? ST_ROW : ST_COL;
          end
        end
      end
      ST_ROW: begin
        if (item.old_byte[cnt]) begin
          m_next[0] = lane_res[0];
          m_next[1] = lane_res[1];
        end else begin
          m_next[2] = lane_res[0];
          m_next[3] = lane_res[1];
        end
        cnt_next = cnt + 1'b1;
        if (cnt == STEP_W'(BYTE_W - 1)) state_next = ST_COL;
      end
      ST_COL: begin
        if (item.new_byte[cnt]) begin
          m_next[1] = lane_res[0];
          m_next[3] = lane_res[1];
        end else begin
          m_next[0] = lane_res[0];
          m_next[2] = lane_res[1];
        end
        cnt_next = cnt + 1'b1;
        if (cnt == STEP_W'(BYTE_W - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to be free
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next.entry_row0_col0 = m[0];
          out_data_next.entry_row0_col1 = m[1];
          out_data_next.entry_row1_col0 = m[2];
          out_data_next.entry_row1_col1 = m[3];
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // modulus write leaves stored entries possibly unreduced
    if (cfg_wr_en) dirty_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dirty     <= 1'b0;
      out_valid <= 1'b0;
      prime     <= PRIME_RESET;
      m[0]      <= ENTRY_W'(1);
      m[1]      <= '0;
      m[2]      <= '0;
      m[3]      <= ENTRY_W'(1);
    end else begin
      state     <= state_next;
      dirty     <= dirty_next;
      out_valid <= out_valid_next;
      for (int i = 0; i < 4; i++) m[i] <= m_next[i];
      if (cfg_wr_en) begin
        // saturate values below three
        prime <= (cfg_wr_data < PRIME_MIN) ? PRIME_MIN : cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item     <= item_next;
    cnt      <= cnt_next;
    bi       <= bi_next;
    sel      <= sel_next;
    out_data <= out_data_next;
    for (int l = 0; l < 2; l++) rem[l] <= rem_next[l];
  end

endmodule
`default_nettype wire
